// ===== sv/canopen_node_guard_monitor_unit_assert.svh =====
// Assertion macros shared by the checker of the node-guard monitor.
`ifndef CANOPEN_NODE_GUARD_MONITOR_UNIT_ASSERT_SVH
`define CANOPEN_NODE_GUARD_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CNGM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CNGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cngm_pkg.sv =====
// ----------------------------------------------------------------------------
// cngm_pkg
// Types, constants and the control program of the node-guard monitor.
// ----------------------------------------------------------------------------
package cngm_pkg;

   localparam int MAX_NODES  = 32;
   localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int PC_W       = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int COND_COUNT = 14;

   localparam logic [6:0]  STATE_UNKNOWN      = 7'h0F;
   localparam logic [6:0]  STATE_DISCONNECTED = 7'h01;
   localparam logic [6:0]  STATE_BOOT         = 7'h00;
   localparam logic [10:0] FRAME_BASE         = 11'h700;
   localparam logic signed [8:0] COUNT_FLOOR  = -9'sd1;

   typedef enum logic [1:0] {
      REG_OWN_NODE_ID,
      REG_GUARD_TIME,
      REG_LIFETIME_FACTOR,
      REG_HEARTBEAT_TIME
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_FRAME,
      OP_GUARD_TICK,
      OP_HEARTBEAT_TICK
   } op_type;

   typedef enum logic [2:0] {
      KIND_GUARD_RESP,
      KIND_HEARTBEAT,
      KIND_STATE_CHANGE,
      KIND_BOOT_UP,
      KIND_GUARD_ERROR,
      KIND_GUARD_REQUEST
   } kind_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       is_remote;
      logic [6:0] source_node;
      logic [7:0] state_byte;
      logic [6:0] own_state;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [6:0]  target_node;
      logic [10:0] frame_id;
      logic [7:0]  data_byte;
      logic        remote_frame;
      logic        last;
   } rsp_type;

   // Conditions the sequencer can test
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_OP_NOT_FRAME,
      C_NOT_REMOTE,
      C_OWN_MATCH,
      C_SRC_OOR,
      C_STATE_DIFF,
      C_NS_ZERO,
      C_NOT_TICK,
      C_GUARD_OFF,
      C_SKIP,
      C_CNT_LE0,
      C_IDX_NOT_LAST,
      C_HB_ON
   } cond_type;

   // Datapath actions
   typedef enum logic [2:0] {
      A_NONE,
      A_TOGGLE,
      A_WRITE_FRAME,
      A_ZERO_IDX,
      A_MARK_DISC,
      A_DEC,
      A_NEXT_IDX,
      A_FLUSH
   } act_type;

   typedef struct packed {
      cond_type          guard;
      act_type           act;
      logic              emit;
      kind_type          kind;
      cond_type          jump;
      logic [PC_W-1:0]   target;
   } ucode_word_type;

   // Program addresses
   localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
   localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
   localparam logic [PC_W-1:0] PC_REMOTE   = 4'd2;
   localparam logic [PC_W-1:0] PC_RESPOND  = 4'd3;
   localparam logic [PC_W-1:0] PC_DATA     = 4'd4;
   localparam logic [PC_W-1:0] PC_CHANGE   = 4'd5;
   localparam logic [PC_W-1:0] PC_RECORD   = 4'd6;
   localparam logic [PC_W-1:0] PC_BOOT     = 4'd7;
   localparam logic [PC_W-1:0] PC_TICK     = 4'd8;
   localparam logic [PC_W-1:0] PC_GUARD_ON = 4'd9;
   localparam logic [PC_W-1:0] PC_LOOP     = 4'd10;
   localparam logic [PC_W-1:0] PC_EXPIRE   = 4'd11;
   localparam logic [PC_W-1:0] PC_REQUEST  = 4'd12;
   localparam logic [PC_W-1:0] PC_NEXT     = 4'd13;
   localparam logic [PC_W-1:0] PC_END      = 4'd14;
   localparam logic [PC_W-1:0] PC_HB       = 4'd15;

   function automatic ucode_word_type uw(input cond_type g, input act_type a,
                                         input logic e, input kind_type k,
                                         input cond_type j,
                                         input logic [PC_W-1:0] t);
      ucode_word_type w;
      w.guard  = g;
      w.act    = a;
      w.emit   = e;
      w.kind   = k;
      w.jump   = j;
      w.target = t;
      return w;
   endfunction

   // Control store: one word per step
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      case (pc)
         PC_DISPATCH: w = uw(C_NEVER, A_NONE, 1'b0, KIND_GUARD_RESP,
                             C_OP_NOT_FRAME, PC_TICK);
         PC_REMOTE:   w = uw(C_NEVER, A_NONE, 1'b0, KIND_GUARD_RESP,
                             C_NOT_REMOTE, PC_DATA);
         PC_RESPOND:  w = uw(C_OWN_MATCH, A_TOGGLE, 1'b1, KIND_GUARD_RESP,
                             C_ALWAYS, PC_END);
         PC_DATA:     w = uw(C_NEVER, A_NONE, 1'b0, KIND_GUARD_RESP,
                             C_SRC_OOR, PC_END);
         PC_CHANGE:   w = uw(C_STATE_DIFF, A_NONE, 1'b1, KIND_STATE_CHANGE,
                             C_NEVER, PC_IDLE);
         PC_RECORD:   w = uw(C_ALWAYS, A_WRITE_FRAME, 1'b0, KIND_GUARD_RESP,
                             C_NEVER, PC_IDLE);
         PC_BOOT:     w = uw(C_NS_ZERO, A_NONE, 1'b1, KIND_BOOT_UP,
                             C_ALWAYS, PC_END);
         PC_TICK:     w = uw(C_ALWAYS, A_ZERO_IDX, 1'b0, KIND_GUARD_RESP,
                             C_NOT_TICK, PC_HB);
         PC_GUARD_ON: w = uw(C_NEVER, A_NONE, 1'b0, KIND_GUARD_RESP,
                             C_GUARD_OFF, PC_END);
         PC_LOOP:     w = uw(C_NEVER, A_NONE, 1'b0, KIND_GUARD_RESP,
                             C_SKIP, PC_NEXT);
         PC_EXPIRE:   w = uw(C_CNT_LE0, A_MARK_DISC, 1'b1, KIND_GUARD_ERROR,
                             C_NEVER, PC_IDLE);
         PC_REQUEST:  w = uw(C_ALWAYS, A_DEC, 1'b1, KIND_GUARD_REQUEST,
                             C_NEVER, PC_IDLE);
         PC_NEXT:     w = uw(C_ALWAYS, A_NEXT_IDX, 1'b0, KIND_GUARD_RESP,
                             C_IDX_NOT_LAST, PC_LOOP);
         PC_END:      w = uw(C_ALWAYS, A_FLUSH, 1'b0, KIND_GUARD_RESP,
                             C_ALWAYS, PC_IDLE);
         PC_HB:       w = uw(C_HB_ON, A_NONE, 1'b1, KIND_HEARTBEAT,
                             C_ALWAYS, PC_END);
         default:     w = uw(C_NEVER, A_NONE, 1'b0, KIND_GUARD_RESP,
                             C_NEVER, PC_IDLE);
      endcase
      return w;
   endfunction

endpackage

// ===== sv/canopen_node_guard_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// canopen_node_guard_monitor_unit
// Node-guarding master/slave and heartbeat producer run by a microcoded
// sequencer over a per-node state and lifetime table.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command by raising start with req_data while busy is low; it is
//   taken at that edge and busy rises the next cycle. Results leave on
//   rsp_data, each for one cycle under rsp_strobe; the final one of a
//   command carries last. The receiver cannot stall, so results are never
//   held back. Commands with no result simply drop busy again.
//   The sequencer runs one control step a cycle and takes no new command
//   until the current one is done; a guard tick walks the nodes in turn,
//   skipping unknown nodes and the own node. Each result shows in the
//   cycle after the step that made the next one, or after the closing step
//   for the last.
//   Registers sit on an APB-style port at byte address 4*index: own node id,
//   guard time, lifetime factor, heartbeat time; pready is always high.
//   Reset makes all nodes unknown with zero counters, clears the toggle bit
//   and loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module canopen_node_guard_monitor_unit import cngm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // configuration registers
   logic [6:0]  own_node_id_ff, own_node_id_in;
   logic [15:0] guard_time_ff, guard_time_in;
   logic [7:0]  lifetime_factor_ff, lifetime_factor_in;
   logic [15:0] heartbeat_time_ff, heartbeat_time_in;

   // node tables and toggle
   logic [6:0]        state_ff [MAX_NODES];
   logic [6:0]        state_in [MAX_NODES];
   logic signed [8:0] count_ff [MAX_NODES];
   logic signed [8:0] count_in [MAX_NODES];
   logic              toggle_ff, toggle_in;

   // sequencer
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [NODE_W-1:0] idx_ff, idx_in;
   req_type           item_ff, item_in;
   rsp_type           pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   ucode_word_type          word;
   logic [COND_COUNT-1:0]   cond_vec;
   logic                    guard_ok, jump_ok, active, emit_fire;
   logic [6:0]              cur_state, new_state, idx_node;
   logic signed [8:0]       cur_count;
   rsp_type                 res;

   logic          csr_write;
   reg_index_type csr_index;
   logic          reload;
   logic [15:0]   gt_next;
   logic [7:0]    lf_next;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   // register read-back
   always_comb begin
      unique case (csr_index)
         REG_OWN_NODE_ID:     prdata = 32'(own_node_id_ff);
         REG_GUARD_TIME:      prdata = 32'(guard_time_ff);
         REG_LIFETIME_FACTOR: prdata = 32'(lifetime_factor_ff);
         REG_HEARTBEAT_TIME:  prdata = 32'(heartbeat_time_ff);
         default:             prdata = '0;
      endcase
   end

   // fetch the control word and read the addressed entry
   assign word      = ucode_rom(pc_ff);
   assign active    = (pc_ff != PC_IDLE);
   assign busy      = active;
   assign cur_state = state_ff[idx_ff];
   assign cur_count = count_ff[idx_ff];
   assign new_state = item_ff.state_byte[6:0];
   assign idx_node  = 7'(idx_ff);

   // evaluate every condition in parallel
   always_comb begin
      cond_vec                 = '0;
      cond_vec[C_NEVER]        = 1'b0;
      cond_vec[C_ALWAYS]       = 1'b1;
      cond_vec[C_OP_NOT_FRAME] = (item_ff.operation != OP_FRAME);
      cond_vec[C_NOT_REMOTE]   = !item_ff.is_remote;
      cond_vec[C_OWN_MATCH]    = (item_ff.source_node == own_node_id_ff);
      cond_vec[C_SRC_OOR]      = (item_ff.source_node >= 7'(MAX_NODES));
      cond_vec[C_STATE_DIFF]   = (cur_state != new_state);
      cond_vec[C_NS_ZERO]      = (new_state == STATE_BOOT);
      cond_vec[C_NOT_TICK]     = (item_ff.operation != OP_GUARD_TICK);
      cond_vec[C_GUARD_OFF]    = (guard_time_ff == '0) || (lifetime_factor_ff == '0);
      cond_vec[C_SKIP]         = (cur_state == STATE_UNKNOWN) ||
                                 (idx_node == own_node_id_ff);
      cond_vec[C_CNT_LE0]      = (cur_count <= 9'sd0);
      cond_vec[C_IDX_NOT_LAST] = (idx_ff != NODE_W'(MAX_NODES - 1));
      cond_vec[C_HB_ON]        = (item_ff.operation == OP_HEARTBEAT_TICK) &&
                                 (heartbeat_time_ff != '0);
   end

   assign guard_ok  = active && cond_vec[word.guard];
   assign jump_ok   = cond_vec[word.jump];
   assign emit_fire = guard_ok && word.emit;

   // build the result of this step
   always_comb begin
      res              = '0;
      res.kind         = word.kind;
      case (word.kind)
         KIND_GUARD_RESP: begin
            res.target_node = own_node_id_ff;
            res.frame_id    = FRAME_BASE + 11'(own_node_id_ff);
            res.data_byte   = {toggle_ff, item_ff.own_state};
         end
         KIND_HEARTBEAT: begin
            res.target_node = own_node_id_ff;
            res.frame_id    = FRAME_BASE + 11'(own_node_id_ff);
            res.data_byte   = {1'b0, item_ff.own_state};
         end
         KIND_STATE_CHANGE: begin
            res.target_node = item_ff.source_node;
            res.data_byte   = {1'b0, new_state};
         end
         KIND_BOOT_UP: begin
            res.target_node = item_ff.source_node;
         end
         KIND_GUARD_ERROR: begin
            res.target_node = idx_node;
         end
         KIND_GUARD_REQUEST: begin
            res.target_node  = idx_node;
            res.frame_id     = FRAME_BASE + 11'(idx_node);
            res.remote_frame = 1'b1;
         end
         default: res = '0;
      endcase
   end

   // advance the step counter and index, latch the command
   always_comb begin
      pc_in   = pc_ff;
      idx_in  = idx_ff;
      item_in = item_ff;
      if (!active) begin
         if (start) begin
            pc_in   = PC_DISPATCH;
            item_in = req_data;
            idx_in  = req_data.source_node[NODE_W-1:0];
         end
      end else begin
         pc_in = jump_ok ? word.target : pc_ff + 1'b1;
         if (guard_ok) begin
            case (word.act)
               A_ZERO_IDX: idx_in = '0;
               A_NEXT_IDX: idx_in = idx_ff + 1'b1;
               default:    idx_in = idx_ff;
            endcase
         end
      end
   end

   // hold one result back so the final one can carry last
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      if (emit_fire) begin
         if (pend_valid_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = pend_ff;
         end
         pend_in       = res;
         pend_valid_in = 1'b1;
      end
      if (guard_ok && (word.act == A_FLUSH) && pend_valid_ff) begin
         rsp_strobe_in    = 1'b1;
         rsp_data_in      = pend_ff;
         rsp_data_in.last = 1'b1;
         pend_valid_in    = 1'b0;
      end
   end

   // register writes and the counter reload they may cause
   always_comb begin
      own_node_id_in     = own_node_id_ff;
      guard_time_in      = guard_time_ff;
      lifetime_factor_in = lifetime_factor_ff;
      heartbeat_time_in  = heartbeat_time_ff;
      gt_next            = guard_time_ff;
      lf_next            = lifetime_factor_ff;
      reload             = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_OWN_NODE_ID:     own_node_id_in = pwdata[6:0];
            REG_GUARD_TIME: begin
               guard_time_in = pwdata[15:0];
               gt_next       = pwdata[15:0];
               reload        = 1'b1;
            end
            REG_LIFETIME_FACTOR: begin
               lifetime_factor_in = pwdata[7:0];
               lf_next            = pwdata[7:0];
               reload             = 1'b1;
            end
            REG_HEARTBEAT_TIME:  heartbeat_time_in = pwdata[15:0];
            default:             own_node_id_in = own_node_id_ff;
         endcase
      end
      reload = reload && (gt_next != '0) && (lf_next != '0);
   end

   // next value of each table entry and of the toggle bit
   always_comb begin
      toggle_in = toggle_ff;
      if (guard_ok && (word.act == A_TOGGLE)) begin
         toggle_in = !toggle_ff;
      end
      if (csr_write && (csr_index == REG_HEARTBEAT_TIME)) begin
         toggle_in = 1'b0;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         state_in[i] = state_ff[i];
         count_in[i] = count_ff[i];
         if (guard_ok && (idx_ff == NODE_W'(i))) begin
            case (word.act)
               A_WRITE_FRAME: begin
                  state_in[i] = new_state;
                  count_in[i] = $signed({1'b0, lifetime_factor_ff});
               end
               A_MARK_DISC: state_in[i] = STATE_DISCONNECTED;
               A_DEC: begin
                  if (cur_count != COUNT_FLOOR) begin
                     count_in[i] = cur_count - 9'sd1;
                  end
               end
               default: count_in[i] = count_ff[i];
            endcase
         end
         if (reload && (state_ff[i] != STATE_UNKNOWN) &&
             (7'(i) != own_node_id_ff)) begin
            count_in[i] = $signed({1'b0, lf_next});
         end
      end
   end

   // control and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_id_ff     <= 7'd1;
         guard_time_ff      <= '0;
         lifetime_factor_ff <= '0;
         heartbeat_time_ff  <= '0;
         toggle_ff          <= 1'b0;
         pc_ff              <= PC_IDLE;
         pend_valid_ff      <= 1'b0;
         rsp_strobe_ff      <= 1'b0;
         for (int i = 0; i < MAX_NODES; i++) begin
            state_ff[i] <= STATE_UNKNOWN;
            count_ff[i] <= '0;
         end
      end else begin
         own_node_id_ff     <= own_node_id_in;
         guard_time_ff      <= guard_time_in;
         lifetime_factor_ff <= lifetime_factor_in;
         heartbeat_time_ff  <= heartbeat_time_in;
         toggle_ff          <= toggle_in;
         pc_ff              <= pc_in;
         pend_valid_ff      <= pend_valid_in;
         rsp_strobe_ff      <= rsp_strobe_in;
         for (int i = 0; i < MAX_NODES; i++) begin
            state_ff[i] <= state_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      item_ff     <= item_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== sv/cngm_checker.sv =====
// ----------------------------------------------------------------------------
// cngm_checker
// Port-level checks of command and result sequencing for the monitor.
// ----------------------------------------------------------------------------
`include "canopen_node_guard_monitor_unit_assert.svh"

module cngm_checker import cngm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // a beat seen once the block is idle again must close the command
   `CNGM_ASSERT_SAME(a_idle_beat_last, clock, reset, rsp_strobe && !busy, rsp_data.last, "beat after idle without last")

   // beats ahead of the last one arrive while the command still runs
   `CNGM_ASSERT_SAME(a_mid_beat_busy, clock, reset, rsp_strobe && !rsp_data.last, busy, "non-final beat while idle")

   // a taken command makes the block busy
   `CNGM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "command taken but not busy")

   // nothing follows the last beat directly
   `CNGM_ASSERT_NEXT(a_last_gap, clock, reset, rsp_strobe && rsp_data.last, !rsp_strobe, "beat right after last")

   // busy only rises from a taken command
   `CNGM_ASSERT_SAME(a_busy_source, clock, reset, $rose(busy), $past(start), "busy rose without start")

endmodule

bind canopen_node_guard_monitor_unit cngm_checker u_cngm_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the node-guard monitor. A table of directed
// commands walks reset behaviour, register extremes and the corner cases of
// guarding, then seven register settings each take a stream of random
// commands. Every accepted command is run through a behavioural copy of the
// node table, counters and toggle bit. Each result beat is compared in order
// with what that copy predicts.
// ----------------------------------------------------------------------------
module testbench;
   import cngm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         PERIOD      = 20;
   localparam int         SETTLE_CYC  = 140;   // longest guard walk plus margin
   localparam int         STALL_LIMIT = 2000;  // cycles with nothing moving
   localparam int         PHASE_QUOTA = 43;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   typedef enum logic [1:0] {FROM_MODEL, TYPED_NONE, TYPED_ONE} check_type;

   typedef struct {
      int        phase;
      req_type   cmd;
      check_type mode;
      rsp_type   typed;
   } stim_row_type;

   // DUT connections; the driven ones are known from time zero
   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  start   = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [31:0]           pwdata  = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Behavioural copy of the block
   logic [6:0]        own_id_q;
   logic [15:0]       guard_time_q;
   logic [7:0]        lifetime_q;
   logic [15:0]       hb_time_q;
   logic [6:0]        node_state_q [MAX_NODES];
   logic signed [8:0] life_count_q [MAX_NODES];
   logic              toggle_q;

   rsp_type       staged_beats [$];
   rsp_type       due_beats [$];
   stim_row_type  directed [$];

   int fault_count   = 0;
   int beats_checked = 0;
   int cmds_sent     = 0;
   int settings_run  = 0;
   int stall_cycles  = 0;

   canopen_node_guard_monitor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #(PERIOD/2) clock = ~clock;

   // Build one result beat; typed rows always hold the final beat
   function automatic rsp_type guard_beat(input kind_type k, input logic [6:0] node,
                                          input logic [10:0] fid, input logic [7:0] data,
                                          input logic rtr);
      rsp_type b;
      b.kind         = k;
      b.target_node  = node;
      b.frame_id     = fid;
      b.data_byte    = data;
      b.remote_frame = rtr;
      b.last         = 1'b1;
      return b;
   endfunction

   function automatic void stage_beat(input kind_type k, input logic [6:0] node,
                                      input logic [10:0] fid, input logic [7:0] data,
                                      input logic rtr);
      rsp_type b;
      b      = guard_beat(k, node, fid, data, rtr);
      b.last = 1'b0;
      staged_beats.push_back(b);
   endfunction

   function automatic void reset_guard_state();
      own_id_q     = 7'd1;
      guard_time_q = '0;
      lifetime_q   = '0;
      hb_time_q    = '0;
      toggle_q     = 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
         node_state_q[i] = STATE_UNKNOWN;
         life_count_q[i] = '0;
      end
   endfunction

   // Register write as the block sees it, including the counter reload
   function automatic void apply_register(input reg_index_type idx, input logic [31:0] v);
      case (idx)
         REG_OWN_NODE_ID:     own_id_q     = v[6:0];
         REG_GUARD_TIME:      guard_time_q = v[15:0];
         REG_LIFETIME_FACTOR: lifetime_q   = v[7:0];
         REG_HEARTBEAT_TIME: begin
            hb_time_q = v[15:0];
            toggle_q  = 1'b0;
         end
      endcase
      if ((idx == REG_GUARD_TIME || idx == REG_LIFETIME_FACTOR) &&
          guard_time_q != 0 && lifetime_q != 0) begin
         for (int i = 0; i < MAX_NODES; i++)
            if (node_state_q[i] != STATE_UNKNOWN && i != own_id_q)
               life_count_q[i] = $signed({1'b0, lifetime_q});
      end
   endfunction

   // Work out the beats one command causes; flag commands that do anything
   function automatic bit predict_guard_beats(input req_type c);
      bit         hit;
      logic [7:0] d;
      logic [6:0] ns;
      logic [4:0] idx;
      hit = 1'b0;
      staged_beats.delete();
      case (c.operation)
         OP_FRAME: begin
            if (c.is_remote) begin
               if (c.source_node == own_id_q) begin
                  hit = 1'b1;
                  d   = {1'b0, c.own_state};
                  if (toggle_q) begin
                     d[7]     = 1'b1;
                     toggle_q = 1'b0;
                  end else begin
                     toggle_q = 1'b1;
                  end
                  stage_beat(KIND_GUARD_RESP, own_id_q, FRAME_BASE + {4'd0, own_id_q}, d,
                             1'b0);
               end
            end else if (c.source_node < MAX_NODES) begin
               hit = 1'b1;
               ns  = c.state_byte[6:0];
               idx = c.source_node[4:0];
               life_count_q[idx] = $signed({1'b0, lifetime_q});
               if (node_state_q[idx] != ns) begin
                  node_state_q[idx] = ns;
                  stage_beat(KIND_STATE_CHANGE, c.source_node, '0, {1'b0, ns}, 1'b0);
               end
               if (node_state_q[idx] == STATE_BOOT)
                  stage_beat(KIND_BOOT_UP, c.source_node, '0, '0, 1'b0);
            end
         end
         OP_GUARD_TICK: begin
            if (guard_time_q != 0 && lifetime_q != 0) begin
               hit = 1'b1;
               for (int i = 0; i < MAX_NODES; i++) begin
                  if (node_state_q[i] == STATE_UNKNOWN || i == own_id_q)
                     continue;
                  if (life_count_q[i] <= 0) begin
                     stage_beat(KIND_GUARD_ERROR, 7'(i), '0, '0, 1'b0);
                     node_state_q[i] = STATE_DISCONNECTED;
                  end
                  if (life_count_q[i] > -1)
                     life_count_q[i] = life_count_q[i] - 9'sd1;
                  stage_beat(KIND_GUARD_REQUEST, 7'(i), FRAME_BASE + 11'(i), '0, 1'b1);
               end
            end
         end
         OP_HEARTBEAT_TICK: begin
            if (hb_time_q != 0) begin
               hit = 1'b1;
               stage_beat(KIND_HEARTBEAT, own_id_q, FRAME_BASE + {4'd0, own_id_q},
                          {1'b0, c.own_state}, 1'b0);
            end
         end
         default: ;
      endcase
      if (staged_beats.size() > 0)
         staged_beats[staged_beats.size() - 1].last = 1'b1;
      return hit;
   endfunction

   // Present one command and hold it until taken; queue what it should cause
   task automatic issue_cmd(input req_type c, input check_type mode, input rsp_type typed,
                            output bit hit);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= c;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      hit = predict_guard_beats(c);
      cmds_sent++;
      case (mode)
         FROM_MODEL: foreach (staged_beats[i]) due_beats.push_back(staged_beats[i]);
         TYPED_ONE:  due_beats.push_back(typed);
         default:    ;
      endcase
   endtask

   // Drop start for a while, with noise on the payload
   task automatic idle_for(input int n);
      if (n > 0) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= req_type'($urandom);
         repeat (n - 1) @(negedge clock);
      end
   endtask

   function automatic int pick_gap(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Wait for every result and for the sequencer to fall quiet
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      forever begin
         @(posedge clock);
         if (due_beats.size() == 0 && !busy)
            break;
      end
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // APB write, then read back and compare
   task automatic write_register(input reg_index_type idx, input logic [31:0] v);
      logic [31:0] mask;
      logic [31:0] wdata;
      case (idx)
         REG_OWN_NODE_ID:     mask = 32'h0000_007F;
         REG_LIFETIME_FACTOR: mask = 32'h0000_00FF;
         default:             mask = 32'h0000_FFFF;
      endcase
      wdata = ($urandom & ~mask) | (v & mask);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      apply_register(idx, wdata);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== (wdata & mask)) begin
         $display("%0t: register %s read back %h, expected %h", $time, idx.name(), prdata,
                  wdata & mask);
         fault_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_setting(input int ph);
      logic [31:0] own, gt, lf, hb;
      case (ph)
         1: begin own = 5; gt = 16'hFFFF; lf = 1; hb = 16'hFFFF; end
         2: begin own = 1; gt = 1; lf = 2; hb = 1; end
         3: begin own = 127; gt = $urandom_range(1, 65535); lf = 255; hb = 0; end
         4: begin own = 3; gt = 0; lf = 3; hb = 16'hFFFF; end
         5: begin
            own = $urandom_range(1, 31);    gt = $urandom_range(1, 65535);
            lf  = $urandom_range(1, 4);     hb = $urandom_range(1, 65535);
         end
         6: begin
            own = $urandom_range(1, 127);   gt = $urandom_range(0, 65535);
            lf  = 0;                        hb = $urandom_range(0, 65535);
         end
         7: begin
            own = $urandom_range(1, 31);    gt = $urandom_range(1, 65535);
            lf  = 1;                        hb = $urandom_range(1, 65535);
         end
         default: begin own = 7'h40; gt = 16'hFFFF; lf = $urandom_range(1, 8); hb = 16'h8000; end
      endcase
      write_register(REG_OWN_NODE_ID, own);
      write_register(REG_GUARD_TIME, gt);
      write_register(REG_LIFETIME_FACTOR, lf);
      write_register(REG_HEARTBEAT_TIME, hb);
      settings_run++;
   endtask

   // Mostly meaningful traffic: frames for tracked nodes, pings for us, ticks
   function automatic req_type draw_cmd();
      req_type c;
      int      r;
      logic [7:0] common_states [6] = '{8'h00, 8'h01, 8'h04, 8'h05, 8'h7F, 8'h0F};
      c = req_type'($urandom);
      r = $urandom_range(0, 99);
      if (r < 55)
         c.operation = OP_FRAME;
      else if (r < 75)
         c.operation = OP_GUARD_TICK;
      else if (r < 92)
         c.operation = OP_HEARTBEAT_TICK;
      else
         c.operation = OP_UNUSED;
      if (c.operation == OP_FRAME) begin
         c.is_remote = ($urandom_range(0, 99) < 35);
         if (c.is_remote)
            c.source_node = ($urandom_range(0, 99) < 70) ? own_id_q : 7'($urandom);
         else if ($urandom_range(0, 99) < 85)
            c.source_node = 7'($urandom_range(0, MAX_NODES - 1));
         else
            c.source_node = 7'($urandom_range(MAX_NODES, 127));
         if ($urandom_range(0, 99) < 70)
            c.state_byte = common_states[$urandom_range(0, 5)] |
                           {1'($urandom_range(0, 1)), 7'd0};
      end
      return c;
   endfunction

   function automatic stim_row_type row(input int ph, input logic [1:0] op, input logic rem,
                                        input logic [6:0] src, input logic [7:0] sb,
                                        input logic [6:0] os, input check_type mode,
                                        input rsp_type typed);
      stim_row_type s;
      s.phase = ph;
      s.cmd   = '{operation: op, is_remote: rem, source_node: src, state_byte: sb,
                  own_state: os};
      s.mode  = mode;
      s.typed = typed;
      return s;
   endfunction

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_beats.size() == 0) begin
            $display("%0t: unexpected result kind=%0d node=%0d id=%h data=%h rtr=%b last=%b",
                     $time, rsp_data.kind, rsp_data.target_node, rsp_data.frame_id,
                     rsp_data.data_byte, rsp_data.remote_frame, rsp_data.last);
            fault_count++;
         end else begin
            want = due_beats.pop_front();
            beats_checked++;
            if (rsp_data.kind !== want.kind || rsp_data.target_node !== want.target_node ||
                rsp_data.frame_id !== want.frame_id || rsp_data.data_byte !== want.data_byte ||
                rsp_data.remote_frame !== want.remote_frame || rsp_data.last !== want.last) begin
               $display("%0t: result mismatch expected kind=%0d node=%0d id=%h data=%h rtr=%b last=%b",
                        $time, want.kind, want.target_node, want.frame_id, want.data_byte,
                        want.remote_frame, want.last);
               $display("%0t:                 actual kind=%0d node=%0d id=%h data=%h rtr=%b last=%b",
                        $time, rsp_data.kind, rsp_data.target_node, rsp_data.frame_id,
                        rsp_data.data_byte, rsp_data.remote_frame, rsp_data.last);
               fault_count++;
            end
         end
      end
   end

   // Abort when nothing has moved for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                  STALL_LIMIT, due_beats.size());
         $display("** canopen_node_guard_monitor_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      bit hit;
      int cur_phase;
      int taken;
      reset_guard_state();

      // Reset settings first, then own id 5 with the tightest guarding
      directed.push_back(row(0, OP_HEARTBEAT_TICK, 0, 1, 8'h00, 7'h7F, TYPED_NONE, '0));
      directed.push_back(row(0, OP_GUARD_TICK, 0, 0, 8'h00, 7'h00, TYPED_NONE, '0));
      directed.push_back(row(0, OP_UNUSED, 1, 1, 8'hFF, 7'h7F, TYPED_NONE, '0));
      directed.push_back(row(0, OP_FRAME, 1, 1, 8'h00, 7'h7F, TYPED_ONE,
                             guard_beat(KIND_GUARD_RESP, 1, 11'h701, 8'h7F, 0)));
      directed.push_back(row(0, OP_FRAME, 1, 1, 8'h00, 7'h05, TYPED_ONE,
                             guard_beat(KIND_GUARD_RESP, 1, 11'h701, 8'h85, 0)));
      directed.push_back(row(0, OP_FRAME, 1, 2, 8'h00, 7'h05, TYPED_NONE, '0));
      directed.push_back(row(0, OP_FRAME, 0, 32, 8'h00, 7'h00, TYPED_NONE, '0));
      directed.push_back(row(0, OP_FRAME, 0, 127, 8'h00, 7'h00, TYPED_NONE, '0));
      directed.push_back(row(0, OP_FRAME, 0, 0, 8'h80, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(0, OP_FRAME, 0, 0, 8'h00, 7'h00, TYPED_ONE,
                             guard_beat(KIND_BOOT_UP, 0, 11'h000, 8'h00, 0)));
      directed.push_back(row(0, OP_FRAME, 0, 31, 8'hFF, 7'h00, TYPED_ONE,
                             guard_beat(KIND_STATE_CHANGE, 31, 11'h000, 8'h7F, 0)));
      directed.push_back(row(0, OP_FRAME, 0, 31, 8'h7F, 7'h00, TYPED_NONE, '0));
      directed.push_back(row(0, OP_FRAME, 0, 5, 8'h05, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(0, OP_FRAME, 0, 1, 8'h7F, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(1, OP_HEARTBEAT_TICK, 0, 0, 8'h00, 7'h7F, TYPED_ONE,
                             guard_beat(KIND_HEARTBEAT, 5, 11'h705, 8'h7F, 0)));
      // Counter runs 1, 0, then sticks at the floor of -1
      directed.push_back(row(1, OP_GUARD_TICK, 0, 0, 8'h00, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(1, OP_GUARD_TICK, 0, 0, 8'h00, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(1, OP_GUARD_TICK, 0, 0, 8'h00, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(1, OP_FRAME, 1, 5, 8'h00, 7'h00, TYPED_ONE,
                             guard_beat(KIND_GUARD_RESP, 5, 11'h705, 8'h00, 0)));
      directed.push_back(row(1, OP_FRAME, 0, 0, 8'h0F, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(1, OP_FRAME, 0, 31, 8'h01, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(1, OP_GUARD_TICK, 0, 0, 8'h00, 7'h00, FROM_MODEL, '0));
      directed.push_back(row(1, OP_HEARTBEAT_TICK, 0, 0, 8'h00, 7'h00, TYPED_ONE,
                             guard_beat(KIND_HEARTBEAT, 5, 11'h705, 8'h00, 0)));
      directed.push_back(row(1, OP_FRAME, 1, 5, 8'h00, 7'h7F, FROM_MODEL, '0));

      // Hold reset, then drop it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      cur_phase = 0;
      foreach (directed[i]) begin
         if (directed[i].phase != cur_phase) begin
            settle();
            cur_phase = directed[i].phase;
            program_setting(cur_phase);
         end
         issue_cmd(directed[i].cmd, directed[i].mode, directed[i].typed, hit);
         idle_for(pick_gap(1'b0));
      end

      // Random traffic under each further setting; bursts in two of them
      for (int ph = 2; ph <= 8; ph++) begin
         settle();
         program_setting(ph);
         taken = 0;
         while (taken < PHASE_QUOTA) begin
            issue_cmd(draw_cmd(), FROM_MODEL, '0, hit);
            if (hit)
               taken++;
            idle_for(pick_gap(ph == 3 || ph == 7));
         end
      end

      settle();
      $display("Ran %0d commands (%0d from the directed table) under %0d register settings",
               cmds_sent, directed.size(), settings_run + 1);
      $display("and checked %0d result beats.", beats_checked);
      if (fault_count == 0)
         $display("** canopen_node_guard_monitor_unit: PASSED **");
      else
         $display("** canopen_node_guard_monitor_unit: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/cngm_pkg.sv
sv/canopen_node_guard_monitor_unit.sv
sv/cngm_checker.sv
sim/testbench.sv
